[rtl/alt_pkg.sv]
// Shared types, codes and character helpers for the assembler line tokenizer.
package alt_pkg;

    typedef enum logic [2:0] {
        M_IDLE,
        M_IDENT,
        M_NUM,
        M_STR,
        M_COMMENT,
        M_GT,
        M_LT
    } mode_t;

    typedef enum logic [3:0] {
        K_EOL      = 4'd0,
        K_IDENT    = 4'd1,
        K_NUMBER   = 4'd2,
        K_STR_CHAR = 4'd3,
        K_STR_END  = 4'd4,
        K_GE       = 4'd5,
        K_LE       = 4'd6,
        K_NE       = 4'd7,
        K_SYMBOL   = 4'd8
    } kind_t;

    typedef enum logic [2:0] {
        E_NONE     = 3'd0,
        E_BAD_OCT  = 3'd1,
        E_BAD_BIN  = 3'd2,
        E_BAD_DEC  = 3'd3,
        E_OPEN_STR = 3'd4,
        E_LONG_ID  = 3'd5
    } err_t;

    // Bit positions in the digit flag register.
    localparam int F_OCT   = 0;
    localparam int F_BIN   = 1;
    localparam int F_DEC   = 2;
    localparam int F_BIN_P = 3;
    localparam int F_DEC_P = 4;
    localparam int F_LONG  = 5;

    localparam int FIFO_DEPTH = 4;

    typedef struct packed {
        mode_t       mode;
        logic [7:0]  quote_char;
        logic [15:0] hash_acc;
        logic [15:0] hash_upper_acc;
        logic [7:0]  first_char;
        logic [8:0]  ident_count;
        logic [4:0]  digit_count;
        logic [15:0] hex_acc;
        logic [15:0] oct_acc;
        logic [15:0] dec_acc;
        logic [15:0] bin_acc;
        logic [15:0] dec_prev;
        logic [15:0] bin_prev;
        logic [5:0]  digit_flags;
        logic [7:0]  last_stored_char;
    } tok_state_t;

    typedef struct packed {
        kind_t       kind;
        logic [15:0] value;
        logic [15:0] hash;
        logic [15:0] hash_upper;
        logic [8:0]  length;
        err_t        error;
        logic        last;
    } tok_res_t;

    // Outcome of handling one byte as between tokens.
    typedef struct packed {
        tok_state_t s;
        logic       emit;
        tok_res_t   r;
    } idle_out_t;

    // Outcome of one full step: new state and up to two results.
    typedef struct packed {
        tok_state_t  s;
        logic [1:0]  n;
        tok_res_t    r0;
        tok_res_t    r1;
    } step_out_t;

    typedef struct packed {
        logic room;
        logic empty;
    } fifo_stat_t;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    function automatic logic is_lower(input logic [7:0] c);
        return (c >= "a") && (c <= "z");
    endfunction

    function automatic logic is_upper(input logic [7:0] c);
        return (c >= "A") && (c <= "Z");
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return c inside {[8'h09:8'h0D], 8'h20};
    endfunction

    function automatic logic is_id_start(input logic [7:0] c);
        return is_lower(c) || is_upper(c) || (c == "_") || (c == "?") || (c == "$");
    endfunction

    function automatic logic is_id_char(input logic [7:0] c);
        return is_id_start(c) || is_digit(c);
    endfunction

    function automatic logic is_hex(input logic [7:0] c);
        return is_digit(c) || ((c >= "a") && (c <= "f")) || ((c >= "A") && (c <= "F"));
    endfunction

    function automatic logic [3:0] hex_val(input logic [7:0] c);
        logic [7:0] v;
        if (is_digit(c))
        begin
            v = c - 8'h30;
        end
        else if ((c >= "a") && (c <= "f"))
        begin
            v = c - 8'h57;
        end
        else
        begin
            v = c - 8'h37;
        end
        return v[3:0];
    endfunction

    function automatic logic [7:0] upcase(input logic [7:0] c);
        return is_lower(c) ? (c - 8'd32) : c;
    endfunction

    function automatic logic [15:0] rotl16(input logic [15:0] x);
        return {x[14:0], x[15]};
    endfunction

    function automatic tok_res_t mk_res(input kind_t k, input logic [15:0] v,
                                        input logic [15:0] h, input logic [15:0] hu,
                                        input logic [8:0] len, input err_t e);
        tok_res_t r;
        r.kind       = k;
        r.value      = v;
        r.hash       = h;
        r.hash_upper = hu;
        r.length     = len;
        r.error      = e;
        r.last       = 1'b0;
        return r;
    endfunction

endpackage

[rtl/alt_core.sv]
// Tokenizer state register and the single-pass step logic for one byte.
module alt_core #(
    parameter int MAX_IDENT    = 511,
    parameter int NUMBER_CHARS = 20
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               fire,
    input  logic [7:0]         ch,
    output alt_pkg::step_out_t step
);
    import alt_pkg::*;

    tok_state_t st_reg;
    tok_state_t st_next;

    function automatic tok_state_t ident_add(input tok_state_t s, input logic [7:0] c);
        tok_state_t t;
        t = s;
        if (s.ident_count >= 9'(MAX_IDENT))
        begin
            t.digit_flags[F_LONG] = 1'b1;
        end
        else
        begin
            t.hash_acc       = rotl16(s.hash_acc ^ {8'd0, c});
            t.hash_upper_acc = rotl16(s.hash_upper_acc ^ {8'd0, upcase(c)});
            t.ident_count    = s.ident_count + 9'd1;
        end
        return t;
    endfunction

    function automatic tok_state_t num_store(input tok_state_t s, input logic [7:0] c);
        tok_state_t t;
        logic [7:0] dv;
        t  = s;
        dv = c - 8'h30;
        if (s.digit_count < 5'(NUMBER_CHARS))
        begin
            t.dec_prev = s.dec_acc;
            t.bin_prev = s.bin_acc;
            t.digit_flags[F_BIN_P] = s.digit_flags[F_BIN];
            t.digit_flags[F_DEC_P] = s.digit_flags[F_DEC];
            t.hex_acc = {s.hex_acc[11:0], 4'd0} + {12'd0, hex_val(c)};
            if (is_digit(c) && (c <= "7"))
            begin
                t.oct_acc = {s.oct_acc[12:0], 3'd0} + {13'd0, dv[2:0]};
            end
            else
            begin
                t.digit_flags[F_OCT] = 1'b1;
            end
            if ((c == "0") || (c == "1"))
            begin
                t.bin_acc = {s.bin_acc[14:0], dv[0]};
            end
            else
            begin
                t.digit_flags[F_BIN] = 1'b1;
            end
            if (is_digit(c))
            begin
                t.dec_acc = 16'(s.dec_acc * 16'd10 + {12'd0, dv[3:0]});
            end
            else
            begin
                t.digit_flags[F_DEC] = 1'b1;
            end
            t.last_stored_char = c;
            t.digit_count      = s.digit_count + 5'd1;
        end
        return t;
    endfunction

    function automatic idle_out_t do_idle(input tok_state_t s, input logic [7:0] c);
        idle_out_t o;
        o.s    = s;
        o.s.mode = M_IDLE;
        o.emit = 1'b0;
        o.r    = mk_res(K_EOL, 16'd0, 16'd0, 16'd0, 9'd0, E_NONE);
        if (c == 8'd0)
        begin
            o.emit = 1'b1;
        end
        else if (c == ";")
        begin
            o.s.mode = M_COMMENT;
            o.emit   = 1'b1;
        end
        else if (is_blank(c))
        begin
            o.emit = 1'b0;
        end
        else if ((c == 8'h27) || (c == 8'h22))
        begin
            o.s.mode       = M_STR;
            o.s.quote_char = c;
        end
        else if (is_id_start(c))
        begin
            o.s.mode           = M_IDENT;
            o.s.hash_acc       = 16'd0;
            o.s.hash_upper_acc = 16'd0;
            o.s.ident_count    = 9'd0;
            o.s.digit_flags    = 6'd0;
            o.s.first_char     = c;
            o.s = ident_add(o.s, c);
        end
        else if (is_digit(c))
        begin
            o.s.mode        = M_NUM;
            o.s.hex_acc     = 16'd0;
            o.s.oct_acc     = 16'd0;
            o.s.dec_acc     = 16'd0;
            o.s.bin_acc     = 16'd0;
            o.s.dec_prev    = 16'd0;
            o.s.bin_prev    = 16'd0;
            o.s.digit_flags = 6'd0;
            o.s.digit_count = 5'd0;
            o.s = num_store(o.s, c);
        end
        else if (c == ">")
        begin
            o.s.mode = M_GT;
        end
        else if (c == "<")
        begin
            o.s.mode = M_LT;
        end
        else
        begin
            o.emit = 1'b1;
            o.r    = mk_res(K_SYMBOL, {8'd0, c}, 16'd0, 16'd0, 9'd0, E_NONE);
        end
        return o;
    endfunction

    // A token that ends on this byte comes first; the byte itself is then
    // treated as between tokens and may add a second result.
    function automatic step_out_t follow(input tok_res_t r0, input tok_state_t s,
                                         input logic [7:0] c);
        step_out_t o;
        idle_out_t id;
        id   = do_idle(s, c);
        o.s  = id.s;
        o.r0 = r0;
        o.r1 = id.r;
        o.n  = id.emit ? 2'd2 : 2'd1;
        return o;
    endfunction

    function automatic step_out_t do_step(input tok_state_t s, input logic [7:0] c);
        step_out_t o;
        idle_out_t id;
        tok_res_t  r;
        logic      bad;
        o.s  = s;
        o.n  = 2'd0;
        o.r0 = mk_res(K_EOL, 16'd0, 16'd0, 16'd0, 9'd0, E_NONE);
        o.r1 = o.r0;
        case (s.mode)
            M_IDENT:
            begin
                if (is_id_char(c))
                begin
                    o.s = ident_add(s, c);
                end
                else
                begin
                    r = mk_res(K_IDENT, 16'd0, s.hash_acc + {8'd0, s.first_char},
                               s.hash_upper_acc + {8'd0, upcase(s.first_char)},
                               s.ident_count,
                               s.digit_flags[F_LONG] ? E_LONG_ID : E_NONE);
                    o = follow(r, s, c);
                end
            end
            M_NUM:
            begin
                if (is_hex(c))
                begin
                    o.s = num_store(s, c);
                end
                else if ((c == "h") || (c == "H"))
                begin
                    o.r0 = mk_res(K_NUMBER, s.hex_acc, 16'd0, 16'd0, 9'd0, E_NONE);
                    o.n  = 2'd1;
                    o.s.mode = M_IDLE;
                end
                else if ((c == "q") || (c == "Q") || (c == "o") || (c == "O"))
                begin
                    bad  = s.digit_flags[F_OCT];
                    o.r0 = mk_res(K_NUMBER, bad ? 16'd0 : s.oct_acc, 16'd0, 16'd0, 9'd0,
                                  bad ? E_BAD_OCT : E_NONE);
                    o.n  = 2'd1;
                    o.s.mode = M_IDLE;
                end
                else
                begin
                    if ((s.last_stored_char == "b") || (s.last_stored_char == "B"))
                    begin
                        bad = s.digit_flags[F_BIN_P];
                        r = mk_res(K_NUMBER, bad ? 16'd0 : s.bin_prev, 16'd0, 16'd0, 9'd0,
                                   bad ? E_BAD_BIN : E_NONE);
                    end
                    else if ((s.last_stored_char == "d") || (s.last_stored_char == "D"))
                    begin
                        bad = s.digit_flags[F_DEC_P];
                        r = mk_res(K_NUMBER, bad ? 16'd0 : s.dec_prev, 16'd0, 16'd0, 9'd0,
                                   bad ? E_BAD_DEC : E_NONE);
                    end
                    else
                    begin
                        bad = s.digit_flags[F_DEC];
                        r = mk_res(K_NUMBER, bad ? 16'd0 : s.dec_acc, 16'd0, 16'd0, 9'd0,
                                   bad ? E_BAD_DEC : E_NONE);
                    end
                    o = follow(r, s, c);
                end
            end
            M_STR:
            begin
                if (c == s.quote_char)
                begin
                    o.r0 = mk_res(K_STR_END, 16'd0, 16'd0, 16'd0, 9'd0, E_NONE);
                    o.n  = 2'd1;
                    o.s.mode = M_IDLE;
                end
                else if (c == 8'd0)
                begin
                    // End of line inside a string closes it with an error.
                    o.r0 = mk_res(K_STR_END, 16'd0, 16'd0, 16'd0, 9'd0, E_OPEN_STR);
                    o.r1 = mk_res(K_EOL, 16'd0, 16'd0, 16'd0, 9'd0, E_NONE);
                    o.n  = 2'd2;
                    o.s.mode = M_IDLE;
                end
                else
                begin
                    o.r0 = mk_res(K_STR_CHAR, {8'd0, c}, 16'd0, 16'd0, 9'd0, E_NONE);
                    o.n  = 2'd1;
                end
            end
            M_COMMENT:
            begin
                if (c == 8'd0)
                begin
                    o.s.mode = M_IDLE;
                end
            end
            M_GT:
            begin
                if (c == "=")
                begin
                    o.r0 = mk_res(K_GE, 16'd0, 16'd0, 16'd0, 9'd0, E_NONE);
                    o.n  = 2'd1;
                    o.s.mode = M_IDLE;
                end
                else
                begin
                    r = mk_res(K_SYMBOL, {8'd0, 8'h3E}, 16'd0, 16'd0, 9'd0, E_NONE);
                    o = follow(r, s, c);
                end
            end
            M_LT:
            begin
                if (c == "=")
                begin
                    o.r0 = mk_res(K_LE, 16'd0, 16'd0, 16'd0, 9'd0, E_NONE);
                    o.n  = 2'd1;
                    o.s.mode = M_IDLE;
                end
                else if (c == ">")
                begin
                    o.r0 = mk_res(K_NE, 16'd0, 16'd0, 16'd0, 9'd0, E_NONE);
                    o.n  = 2'd1;
                    o.s.mode = M_IDLE;
                end
                else
                begin
                    r = mk_res(K_SYMBOL, {8'd0, 8'h3C}, 16'd0, 16'd0, 9'd0, E_NONE);
                    o = follow(r, s, c);
                end
            end
            default:
            begin
                id = do_idle(s, c);
                o.s  = id.s;
                o.r0 = id.r;
                o.n  = id.emit ? 2'd1 : 2'd0;
            end
        endcase
        o.r0.last = (o.n == 2'd1);
        o.r1.last = (o.n == 2'd2);
        return o;
    endfunction

    assign step = do_step(st_reg, ch);

    always_comb
    begin
        st_next = fire ? step.s : st_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= '0;
        end
        else
        begin
            st_reg <= st_next;
        end
    end

endmodule

[rtl/alt_fifo.sv]
// Result queue that takes up to two results per cycle and delivers one per cycle when popped.
module alt_fifo (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [1:0]          push_n,
    input  alt_pkg::tok_res_t   w0,
    input  alt_pkg::tok_res_t   w1,
    input  logic                pop,
    output alt_pkg::tok_res_t   rd,
    output alt_pkg::fifo_stat_t stat
);
    import alt_pkg::*;

    localparam int PW = $clog2(FIFO_DEPTH);
    localparam int CW = $clog2(FIFO_DEPTH + 1);

    tok_res_t      mem_reg [FIFO_DEPTH];
    logic [PW-1:0] wptr_reg;
    logic [PW-1:0] wptr_next;
    logic [PW-1:0] rptr_reg;
    logic [PW-1:0] rptr_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic [PW-1:0] wptr_1;

    assign wptr_1 = wptr_reg + PW'(1);

    always_comb
    begin
        wptr_next  = wptr_reg + PW'(push_n);
        rptr_next  = pop ? (rptr_reg + PW'(1)) : rptr_reg;
        count_next = count_reg + CW'(push_n) - CW'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push_n != 2'd0)
        begin
            mem_reg[wptr_reg] <= w0;
        end
        if (push_n == 2'd2)
        begin
            mem_reg[wptr_1] <= w1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    assign rd         = mem_reg[rptr_reg];
    assign stat.empty = (count_reg == '0);
    // Room for the worst case of two results from one byte.
    assign stat.room  = (count_reg <= CW'(FIFO_DEPTH - 2));

endmodule

[rtl/assembler_line_tokenizer_core.sv]
// Top level of the assembler line tokenizer: input register, step core, result queue.
// A byte is held in the input register and stepped once the queue has room; its results are
// written into the queue. Throughput: one byte per cycle; a byte that ends a token and is
// itself a symbol or an end of line gives two results, drained by the four-entry queue at
// one per cycle unless out_stall; the input stalls only while the queue lacks room for two.
// Reset: rst_n (asynchronous, active low) returns to between tokens and empties both stages.
module assembler_line_tokenizer_core #(
    parameter int MAX_IDENT    = 511,
    parameter int NUMBER_CHARS = 20
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  ch,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [3:0]  kind,
    output logic [15:0] value,
    output logic [15:0] hash,
    output logic [15:0] hash_upper,
    output logic [8:0]  length,
    output logic [2:0]  error,
    output logic        last
);
    import alt_pkg::*;

    logic       in_full_reg;
    logic       in_full_next;
    logic [7:0] ch_reg;
    logic       accept;
    logic       fire;
    logic       pop;
    logic [1:0] push_n;
    step_out_t  step;
    fifo_stat_t fstat;
    tok_res_t   rd;

    assign fire     = in_full_reg && fstat.room;
    assign in_stall = in_full_reg && !fstat.room;
    assign accept   = in_valid && !in_stall;
    assign push_n   = fire ? step.n : 2'd0;
    assign pop      = out_valid && !out_stall;

    always_comb
    begin
        in_full_next = accept || (in_full_reg && !fire);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg <= 1'b0;
        end
        else
        begin
            in_full_reg <= in_full_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ch_reg <= ch;
        end
    end

    alt_core #(
        .MAX_IDENT    (MAX_IDENT),
        .NUMBER_CHARS (NUMBER_CHARS)
    ) u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (fire),
        .ch    (ch_reg),
        .step  (step)
    );

    alt_fifo u_fifo (
        .clk    (clk),
        .rst_n  (rst_n),
        .push_n (push_n),
        .w0     (step.r0),
        .w1     (step.r1),
        .pop    (pop),
        .rd     (rd),
        .stat   (fstat)
    );

    assign out_valid  = !fstat.empty;
    assign kind       = rd.kind;
    assign value      = rd.value;
    assign hash       = rd.hash;
    assign hash_upper = rd.hash_upper;
    assign length     = rd.length;
    assign error      = rd.error;
    assign last       = rd.last;

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !in_full_reg |-> !in_stall)
        else $error("input stalled with an empty input register");

    a_at_most_two: assert property (@(posedge clk) disable iff (!rst_n)
        fire |-> (step.n != 2'd3))
        else $error("step produced more than two results");

    a_result_shows: assert property (@(posedge clk) disable iff (!rst_n)
        (push_n != 2'd0) |=> out_valid)
        else $error("pushed result not offered on the output");

    a_two_results_last: assert property (@(posedge clk) disable iff (!rst_n)
        (push_n == 2'd2) |-> (!step.r0.last && step.r1.last))
        else $error("last flag wrong on a two-result item");

endmodule

[test/tb_top.sv]
// Self-checking testbench for the assembler line tokenizer core.
`timescale 1ns / 100ps

module tb_top;
    import alt_pkg::*;

    localparam int NAME_MAX       = 511;
    localparam int NUM_DIGITS_MAX = 20;
    localparam int CYCLE_LIMIT    = 400000;
    localparam int HOLD_AT        = 50;
    localparam int HOLD_CYCLES    = 120;

    // Tracks the tokenizer state byte by byte and holds the tokens still owed by the block.
    class token_scoreboard;
        tok_res_t    token_q[$];
        int          fails;
        mode_t       tok_mode;
        logic [7:0]  quote;
        logic [15:0] id_hash;
        logic [15:0] id_hash_up;
        logic [7:0]  id_first;
        logic [8:0]  id_len;
        logic [4:0]  num_len;
        logic [15:0] hex_v;
        logic [15:0] oct_v;
        logic [15:0] dec_v;
        logic [15:0] bin_v;
        logic [15:0] dec_prev;
        logic [15:0] bin_prev;
        logic [5:0]  flags;
        logic [7:0]  num_last;

        function new();
            fails      = 0;
            tok_mode   = M_IDLE;
            quote      = 8'h00;
            id_hash    = 16'h0000;
            id_hash_up = 16'h0000;
            id_first   = 8'h00;
            id_len     = 9'd0;
            num_len    = 5'd0;
            hex_v      = 16'h0000;
            oct_v      = 16'h0000;
            dec_v      = 16'h0000;
            bin_v      = 16'h0000;
            dec_prev   = 16'h0000;
            bin_prev   = 16'h0000;
            flags      = 6'd0;
            num_last   = 8'h00;
        endfunction

        function bit ch_digit(logic [7:0] c);
            return (c >= "0") && (c <= "9");
        endfunction

        function bit ch_lower(logic [7:0] c);
            return (c >= "a") && (c <= "z");
        endfunction

        function bit ch_name_start(logic [7:0] c);
            return ch_lower(c) || ((c >= "A") && (c <= "Z")) || (c == "_") || (c == "?")
                || (c == "$");
        endfunction

        function logic [7:0] ch_upcase(logic [7:0] c);
            return ch_lower(c) ? c - 8'd32 : c;
        endfunction

        function void push_tok(kind_t k, logic [15:0] v, logic [15:0] h, logic [15:0] hu,
                               logic [8:0] len, err_t e);
            tok_res_t r;
            r.kind       = k;
            r.value      = v;
            r.hash       = h;
            r.hash_upper = hu;
            r.length     = len;
            r.error      = e;
            r.last       = 1'b0;
            token_q.push_back(r);
        endfunction

        function void ident_take(logic [7:0] c);
            logic [15:0] t;
            logic [15:0] tu;
            if (id_len >= NAME_MAX)
            begin
                flags[F_LONG] = 1'b1;
                return;
            end
            t          = id_hash ^ {8'h00, c};
            tu         = id_hash_up ^ {8'h00, ch_upcase(c)};
            id_hash    = {t[14:0], t[15]};
            id_hash_up = {tu[14:0], tu[15]};
            id_len     = id_len + 9'd1;
        endfunction

        function void num_take(logic [7:0] c);
            logic [5:0] f;
            if (num_len >= NUM_DIGITS_MAX)
                return;
            dec_prev   = dec_v;
            bin_prev   = bin_v;
            f          = flags;
            f[F_BIN_P] = flags[F_BIN];
            f[F_DEC_P] = flags[F_DEC];
            hex_v = {hex_v[11:0], ch_digit(c) ? c[3:0] : c[3:0] + 4'd9};
            if (ch_digit(c) && (c <= "7"))
                oct_v = {oct_v[12:0], c[2:0]};
            else
                f[F_OCT] = 1'b1;
            if ((c == "0") || (c == "1"))
                bin_v = {bin_v[14:0], c[0]};
            else
                f[F_BIN] = 1'b1;
            if (ch_digit(c))
                dec_v = dec_v * 16'd10 + {12'h000, c[3:0]};
            else
                f[F_DEC] = 1'b1;
            flags    = f;
            num_last = c;
            num_len  = num_len + 5'd1;
        endfunction

        // Handles a byte that arrives with no token open.
        function void between(logic [7:0] c);
            tok_mode = M_IDLE;
            if (c == 8'h00)
                push_tok(K_EOL, 16'h0, 16'h0, 16'h0, 9'd0, E_NONE);
            else if (c == ";")
            begin
                tok_mode = M_COMMENT;
                push_tok(K_EOL, 16'h0, 16'h0, 16'h0, 9'd0, E_NONE);
            end
            else if (((c >= 8'h09) && (c <= 8'h0D)) || (c == 8'h20))
            begin
            end
            else if ((c == "'") || (c == "\""))
            begin
                tok_mode = M_STR;
                quote    = c;
            end
            else if (ch_name_start(c))
            begin
                tok_mode   = M_IDENT;
                id_hash    = 16'h0000;
                id_hash_up = 16'h0000;
                id_len     = 9'd0;
                flags      = 6'd0;
                id_first   = c;
                ident_take(c);
            end
            else if (ch_digit(c))
            begin
                tok_mode = M_NUM;
                hex_v    = 16'h0000;
                oct_v    = 16'h0000;
                dec_v    = 16'h0000;
                bin_v    = 16'h0000;
                dec_prev = 16'h0000;
                bin_prev = 16'h0000;
                flags    = 6'd0;
                num_len  = 5'd0;
                num_take(c);
            end
            else if (c == ">")
                tok_mode = M_GT;
            else if (c == "<")
                tok_mode = M_LT;
            else
                push_tok(K_SYMBOL, {8'h00, c}, 16'h0, 16'h0, 9'd0, E_NONE);
        endfunction

        function void predict_tokens(logic [7:0] c);
            int       n0;
            tok_res_t r;
            n0 = token_q.size();
            case (tok_mode)
                M_IDENT:
                begin
                    if (ch_name_start(c) || ch_digit(c))
                        ident_take(c);
                    else
                    begin
                        push_tok(K_IDENT, 16'h0, id_hash + {8'h00, id_first},
                                 id_hash_up + {8'h00, ch_upcase(id_first)}, id_len,
                                 flags[F_LONG] ? E_LONG_ID : E_NONE);
                        between(c);
                    end
                end
                M_NUM:
                begin
                    if (ch_digit(c) || ((c >= "a") && (c <= "f")) || ((c >= "A") && (c <= "F")))
                        num_take(c);
                    else if ((c == "h") || (c == "H"))
                    begin
                        push_tok(K_NUMBER, hex_v, 16'h0, 16'h0, 9'd0, E_NONE);
                        tok_mode = M_IDLE;
                    end
                    else if ((c == "q") || (c == "Q") || (c == "o") || (c == "O"))
                    begin
                        push_tok(K_NUMBER, flags[F_OCT] ? 16'h0 : oct_v, 16'h0, 16'h0, 9'd0,
                                 flags[F_OCT] ? E_BAD_OCT : E_NONE);
                        tok_mode = M_IDLE;
                    end
                    else
                    begin
                        // A trailing b or d among the stored characters acts as the radix suffix.
                        if ((num_last == "b") || (num_last == "B"))
                            push_tok(K_NUMBER, flags[F_BIN_P] ? 16'h0 : bin_prev, 16'h0, 16'h0,
                                     9'd0, flags[F_BIN_P] ? E_BAD_BIN : E_NONE);
                        else if ((num_last == "d") || (num_last == "D"))
                            push_tok(K_NUMBER, flags[F_DEC_P] ? 16'h0 : dec_prev, 16'h0, 16'h0,
                                     9'd0, flags[F_DEC_P] ? E_BAD_DEC : E_NONE);
                        else
                            push_tok(K_NUMBER, flags[F_DEC] ? 16'h0 : dec_v, 16'h0, 16'h0,
                                     9'd0, flags[F_DEC] ? E_BAD_DEC : E_NONE);
                        between(c);
                    end
                end
                M_STR:
                begin
                    if (c == quote)
                    begin
                        push_tok(K_STR_END, 16'h0, 16'h0, 16'h0, 9'd0, E_NONE);
                        tok_mode = M_IDLE;
                    end
                    else if (c == 8'h00)
                    begin
                        push_tok(K_STR_END, 16'h0, 16'h0, 16'h0, 9'd0, E_OPEN_STR);
                        push_tok(K_EOL, 16'h0, 16'h0, 16'h0, 9'd0, E_NONE);
                        tok_mode = M_IDLE;
                    end
                    else
                        push_tok(K_STR_CHAR, {8'h00, c}, 16'h0, 16'h0, 9'd0, E_NONE);
                end
                M_COMMENT:
                begin
                    if (c == 8'h00)
                        tok_mode = M_IDLE;
                end
                M_GT:
                begin
                    if (c == "=")
                    begin
                        push_tok(K_GE, 16'h0, 16'h0, 16'h0, 9'd0, E_NONE);
                        tok_mode = M_IDLE;
                    end
                    else
                    begin
                        push_tok(K_SYMBOL, 16'h003E, 16'h0, 16'h0, 9'd0, E_NONE);
                        between(c);
                    end
                end
                M_LT:
                begin
                    if (c == "=")
                    begin
                        push_tok(K_LE, 16'h0, 16'h0, 16'h0, 9'd0, E_NONE);
                        tok_mode = M_IDLE;
                    end
                    else if (c == ">")
                    begin
                        push_tok(K_NE, 16'h0, 16'h0, 16'h0, 9'd0, E_NONE);
                        tok_mode = M_IDLE;
                    end
                    else
                    begin
                        push_tok(K_SYMBOL, 16'h003C, 16'h0, 16'h0, 9'd0, E_NONE);
                        between(c);
                    end
                end
                default:
                    between(c);
            endcase
            if (token_q.size() > n0)
            begin
                r      = token_q.pop_back();
                r.last = 1'b1;
                token_q.push_back(r);
            end
        endfunction

        function void check_result(tok_res_t got);
            tok_res_t want;
            bit       bad;
            if (token_q.size() == 0)
            begin
                fails++;
                if (fails <= 10)
                    $display("unexpected: kind %0d val %h hash %h up %h len %0d err %0d",
                             got.kind, got.value, got.hash, got.hash_upper, got.length,
                             got.error);
                return;
            end
            want = token_q.pop_front();
            bad  = (got.kind !== want.kind) || (got.value !== want.value)
                || (got.hash !== want.hash) || (got.hash_upper !== want.hash_upper)
                || (got.length !== want.length) || (got.error !== want.error)
                || (got.last !== want.last);
            if (bad)
            begin
                fails++;
                if (fails <= 10)
                begin
                    $display("expected: kind %0d val %h hash %h up %h len %0d err %0d last %0b",
                             want.kind, want.value, want.hash, want.hash_upper, want.length,
                             want.error, want.last);
                    $display("actual:   kind %0d val %h hash %h up %h len %0d err %0d last %0b",
                             got.kind, got.value, got.hash, got.hash_upper, got.length,
                             got.error, got.last);
                end
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  ch = 8'h00;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [3:0]  kind;
    logic [15:0] value;
    logic [15:0] hash;
    logic [15:0] hash_upper;
    logic [8:0]  length;
    logic [2:0]  error;
    logic        last;

    token_scoreboard sb;
    logic [7:0]      stim_q[$];
    int              send_idle_pct = 0;
    int              recv_stall_pct = 0;
    int              bytes_taken = 0;
    int              hold_left = 0;
    bit              hold_done = 1'b0;
    int              cycle_count = 0;
    tok_res_t        seen_tok;
    string           name_set = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz_?$0123456789";
    string           hex_set = "0123456789abcdefABCDEF";
    string           punct_set = ",+-*/()=#@!&|%^~[]{}.:";

    assembler_line_tokenizer_core dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .ch         (ch),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .kind       (kind),
        .value      (value),
        .hash       (hash),
        .hash_upper (hash_upper),
        .length     (length),
        .error      (error),
        .last       (last)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("assembler_line_tokenizer_core: mismatch");
            $finish;
        end
    end

    // Receiver: random stalls, plus one long hold-off early on so the block backs up.
    always @(posedge clk)
    begin
        if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end
        else if (!hold_done && (bytes_taken >= HOLD_AT))
        begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
            bytes_taken <= bytes_taken + 1;
        if (rst_n && out_valid && !out_stall)
        begin
            seen_tok.kind       = kind_t'(kind);
            seen_tok.value      = value;
            seen_tok.hash       = hash;
            seen_tok.hash_upper = hash_upper;
            seen_tok.length     = length;
            seen_tok.error      = err_t'(error);
            seen_tok.last       = last;
            sb.check_result(seen_tok);
        end
    end

    function automatic void push_text(string s);
        for (int i = 0; i < s.len(); i++)
            stim_q.push_back(s[i]);
    endfunction

    function automatic void gen_ident(int len);
        stim_q.push_back(name_set[$urandom_range(0, 54)]);
        for (int i = 1; i < len; i++)
            stim_q.push_back(name_set[$urandom_range(0, 64)]);
    endfunction

    function automatic void gen_number();
        int         style;
        int         len;
        logic [7:0] c;
        style = $urandom_range(0, 5);
        len   = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 25) : $urandom_range(1, 5);
        for (int i = 0; i < len; i++)
        begin
            case (style)
                1:       c = "0" + 8'($urandom_range(0, 7));
                2:       c = "0" + 8'($urandom_range(0, 1));
                3, 4:    c = "0" + 8'($urandom_range(0, 9));
                default:
                begin
                    if (i == 0)
                        c = "0" + 8'($urandom_range(0, 9));
                    else
                        c = hex_set[$urandom_range(0, 21)];
                end
            endcase
            stim_q.push_back(c);
        end
        // Now and then a stray hex character is appended, which may spoil the radix.
        if ($urandom_range(0, 4) == 0)
            stim_q.push_back(hex_set[$urandom_range(0, 21)]);
        case (style)
            0:  stim_q.push_back($urandom_range(0, 1) ? "h" : "H");
            1:
            begin
                c = "q";
                case ($urandom_range(0, 3))
                    1:       c = "Q";
                    2:       c = "o";
                    3:       c = "O";
                    default: c = "q";
                endcase
                stim_q.push_back(c);
            end
            2:  stim_q.push_back($urandom_range(0, 1) ? "b" : "B");
            3:  stim_q.push_back($urandom_range(0, 1) ? "d" : "D");
            default:
            begin
            end
        endcase
    endfunction

    function automatic void gen_string();
        logic [7:0] q;
        logic [7:0] c;
        int         n;
        q = $urandom_range(0, 1) ? "'" : "\"";
        stim_q.push_back(q);
        n = $urandom_range(0, 6);
        for (int i = 0; i < n; i++)
        begin
            c = 8'($urandom_range(1, 255));
            if (c == q)
                c = "x";
            stim_q.push_back(c);
        end
        stim_q.push_back(($urandom_range(0, 9) == 0) ? 8'h00 : q);
    endfunction

    function automatic void gen_line();
        int ntok;
        int pick;
        int k;
        ntok = $urandom_range(1, 8);
        for (int t = 0; t < ntok; t++)
        begin
            repeat ($urandom_range(0, 2))
            begin
                k = $urandom_range(0, 5);
                stim_q.push_back((k == 5) ? 8'h20 : 8'h09 + 8'(k));
            end
            pick = $urandom_range(0, 99);
            if (pick < 25)
                gen_ident($urandom_range(1, 10));
            else if (pick < 50)
                gen_number();
            else if (pick < 62)
                gen_string();
            else if (pick < 72)
            begin
                case ($urandom_range(0, 6))
                    0:       push_text(">=");
                    1:       push_text("<=");
                    2:       push_text("<>");
                    3:       push_text(">");
                    4:       push_text("<");
                    5:       push_text("<<");
                    default: push_text("><");
                endcase
            end
            else if (pick < 82)
                stim_q.push_back($urandom_range(0, 1) ? punct_set[$urandom_range(0, 21)]
                                                      : 8'($urandom_range(128, 255)));
            else if (pick < 90)
                stim_q.push_back(8'($urandom_range(0, 255)));
            else
            begin
                // A comment runs to the end of the line.
                stim_q.push_back(";");
                repeat ($urandom_range(0, 6))
                    stim_q.push_back(8'($urandom_range(1, 255)));
                break;
            end
        end
        stim_q.push_back(8'h00);
    endfunction

    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        ch       <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.predict_tokens(b);
    endtask

    initial
    begin
        int n_dir;
        int n_all;
        int q1;
        int q2;
        int q3;
        sb = new();
        push_text("ab1,7Fh19q12b 1Ad,>=<><='a");
        stim_q.push_back(8'h00);
        push_text(";z");
        stim_q.push_back(8'h00);
        stim_q.push_back(8'hFF);
        n_dir = stim_q.size();
        while (stim_q.size() < n_dir + 800)
            gen_line();
        // Identifiers at and just beyond the length limit.
        gen_ident(NAME_MAX);
        stim_q.push_back(" ");
        gen_ident($urandom_range(NAME_MAX + 1, NAME_MAX + 20));
        stim_q.push_back(8'h00);
        while (stim_q.size() < n_dir + 1850)
            gen_line();
        n_all = stim_q.size();
        q1    = n_dir + (n_all - n_dir) / 4;
        q2    = n_dir + (n_all - n_dir) / 2;
        q3    = n_dir + 3 * (n_all - n_dir) / 4;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        for (int i = 0; i < n_all; i++)
        begin
            if (i == q1)
            begin
                send_idle_pct  = 65;
                recv_stall_pct = 0;
            end
            else if (i == q2)
            begin
                // Let the block drain completely before the next phase.
                in_valid <= 1'b0;
                @(posedge clk);
                while (sb.token_q.size() != 0)
                    @(posedge clk);
                send_idle_pct  = 0;
                recv_stall_pct = 65;
            end
            else if (i == q3)
            begin
                send_idle_pct  = 6;
                recv_stall_pct = 6;
            end
            send_byte(stim_q[i]);
        end
        in_valid <= 1'b0;
        while (sb.token_q.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if ((sb.fails == 0) && (sb.token_q.size() == 0))
            $display("assembler_line_tokenizer_core: match");
        else
            $display("assembler_line_tokenizer_core: mismatch");
        $finish;
    end

endmodule
